>>> src/imss_pkg.sv
// ----------------------------------------------------------------------------
// imss_pkg
// Shared types, request/phase/status codes and defaults for the I2C master
// message sequencer.
// ----------------------------------------------------------------------------
package imss_pkg;

	// default depth of the message table
	localparam int MAX_MSGS_DEF = 8;

	// request codes
	localparam logic [2:0] REQ_LOAD    = 3'd0;
	localparam logic [2:0] REQ_START   = 3'd1;
	localparam logic [2:0] REQ_TX_RDY  = 3'd2;
	localparam logic [2:0] REQ_RX_RDY  = 3'd3;
	localparam logic [2:0] REQ_TX_END  = 3'd4;
	localparam logic [2:0] REQ_ERROR   = 3'd5;
	localparam logic [2:0] REQ_TIMEOUT = 3'd6;

	// sequencer phases
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_START   = 4'd1;
	localparam logic [3:0] PH_ADDR_WR = 4'd2;
	localparam logic [3:0] PH_DATA_WR = 4'd3;
	localparam logic [3:0] PH_RESTART = 4'd4;
	localparam logic [3:0] PH_ADDR_RD = 4'd5;
	localparam logic [3:0] PH_DATA_RD = 4'd6;
	localparam logic [3:0] PH_STOP    = 4'd7;
	localparam logic [3:0] PH_ERROR   = 4'd8;

	// transfer status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NACK    = 2'd1;
	localparam logic [1:0] ST_ARB     = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// r/w bit of the address byte, and the byte count where nack is armed
	localparam logic [7:0]  ADDR_RD_BIT = 8'h01;
	localparam logic [15:0] NACK_AT     = 16'd2;

	// one message table entry
	typedef struct packed {
		logic [15:0] len;
		logic        no_start;
		logic        rd;
		logic [6:0]  addr;
	} msg_entry_t;

	// one input item
	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  msg_slot;
		logic [6:0]  dev_addr;
		logic        is_read;
		logic        no_start;
		logic [15:0] msg_length;
		logic [3:0]  msg_count;
		logic [7:0]  tx_byte;
		logic [7:0]  rx_byte;
		logic [2:0]  err_flags;
		logic        stop_seen;
	} item_t;

	// one result item
	typedef struct packed {
		logic       issue_start;
		logic       issue_restart;
		logic       issue_stop;
		logic       tx_valid;
		logic [7:0] tx_data;
		logic       rx_store;
		logic [7:0] rx_data;
		logic       set_nack;
		logic       enter_receive;
		logic       tx_irq_off;
		logic       done_res;
		logic [1:0] status;
	} result_t;

endpackage

>>> src/i2c_master_message_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_message_sequencer_unit
// Multi-message I2C master transfer sequencer driven by bus events.
// ----------------------------------------------------------------------------
// Every accepted item (table load, start, bus event, error or timeout) gives
// exactly one result item. An item is taken into an input register, its step
// is worked out against the sequencer state and the message table, and the
// result is held in an output register, from which it is shown on the output.
// One item can be accepted in every cycle while out_ready does not hold back
// a full output register. The message table is a memory with two registered
// read ports that are prefetched for the next item (current and following
// message). Table entries are undefined until loaded; there is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module i2c_master_message_sequencer_unit #(
	parameter int MAX_MSGS = imss_pkg::MAX_MSGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [2:0]  msg_slot,
	input  logic [6:0]  dev_addr,
	input  logic        is_read,
	input  logic        no_start,
	input  logic [15:0] msg_length,
	input  logic [3:0]  msg_count,
	input  logic [7:0]  tx_byte,
	input  logic [7:0]  rx_byte,
	input  logic [2:0]  err_flags,
	input  logic        stop_seen,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        issue_start,
	output logic        issue_restart,
	output logic        issue_stop,
	output logic        tx_valid,
	output logic [7:0]  tx_data,
	output logic        rx_store,
	output logic [7:0]  rx_data,
	output logic        set_nack,
	output logic        enter_receive,
	output logic        tx_irq_off,
	output logic        done_res,
	output logic [1:0]  status
);
	import imss_pkg::*;

	localparam int IDX_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;

	item_t            item_s1;
	logic             v_s1;
	result_t          res_s2;
	logic             v_s2;
	result_t          res_d;
	logic             s2_free;
	logic             fire;
	logic             wr_en;
	logic [IDX_W-1:0] wr_slot;
	msg_entry_t       wr_data;
	logic [IDX_W-1:0] rd_addr_nxt;
	logic [IDX_W-1:0] rd_addr_cur;
	msg_entry_t       ent_nxt;
	msg_entry_t       ent_cur;

	// handshake: the step runs when the input register moves on
	assign s2_free  = !v_s2 || out_ready;
	assign fire     = v_s1 && s2_free;
	assign in_ready = !v_s1 || s2_free;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (s2_free) begin
				v_s2 <= fire;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{req_type: req_type, msg_slot: msg_slot, dev_addr: dev_addr,
			             is_read: is_read, no_start: no_start, msg_length: msg_length,
			             msg_count: msg_count, tx_byte: tx_byte, rx_byte: rx_byte,
			             err_flags: err_flags, stop_seen: stop_seen};
		end
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	// message table
	imss_msg_mem #(
		.MAX_MSGS (MAX_MSGS)
	) u_mem (
		.clk         (clk),
		.wr_en       (wr_en),
		.wr_slot     (wr_slot),
		.wr_data     (wr_data),
		.rd_addr_nxt (rd_addr_nxt),
		.rd_addr_cur (rd_addr_cur),
		.ent_nxt_q   (ent_nxt),
		.ent_cur_q   (ent_cur)
	);

	// sequencer state and step logic
	imss_seq_core #(
		.MAX_MSGS (MAX_MSGS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.ent_nxt     (ent_nxt),
		.ent_cur     (ent_cur),
		.res         (res_d),
		.wr_en       (wr_en),
		.wr_slot     (wr_slot),
		.wr_data     (wr_data),
		.rd_addr_nxt (rd_addr_nxt),
		.rd_addr_cur (rd_addr_cur)
	);

	// result ports
	assign out_valid     = v_s2;
	assign issue_start   = res_s2.issue_start;
	assign issue_restart = res_s2.issue_restart;
	assign issue_stop    = res_s2.issue_stop;
	assign tx_valid      = res_s2.tx_valid;
	assign tx_data       = res_s2.tx_data;
	assign rx_store      = res_s2.rx_store;
	assign rx_data       = res_s2.rx_data;
	assign set_nack      = res_s2.set_nack;
	assign enter_receive = res_s2.enter_receive;
	assign tx_irq_off    = res_s2.tx_irq_off;
	assign done_res      = res_s2.done_res;
	assign status        = res_s2.status;

`ifndef NO_ASSERTIONS
	// an accepted transfer always lands in the input register
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item lost before step");

	// at most one bus condition per result
	a_one_condition: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones({issue_start, issue_restart, issue_stop}) <= 1))
		else $error("more than one bus condition in one result");

	// data fields are zero unless qualified
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> (tx_data == 8'h00))
		else $error("tx_data set without tx_valid");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> (status == ST_OK))
		else $error("status set without done");

	// nack request only comes with a stored byte
	a_nack_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && set_nack |-> rx_store)
		else $error("nack request without received byte");
`endif

endmodule

>>> src/imss_msg_mem.sv
// ----------------------------------------------------------------------------
// imss_msg_mem
// Message table: one write port, two registered read ports with
// write-through so a read in the same cycle as a load sees the new entry.
// ----------------------------------------------------------------------------
module imss_msg_mem #(
	parameter int MAX_MSGS = imss_pkg::MAX_MSGS_DEF,
	localparam int IDX_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_slot,
	input  imss_pkg::msg_entry_t wr_data,
	input  logic [IDX_W-1:0]     rd_addr_nxt,
	input  logic [IDX_W-1:0]     rd_addr_cur,
	output imss_pkg::msg_entry_t ent_nxt_q,
	output imss_pkg::msg_entry_t ent_cur_q
);
	import imss_pkg::*;

	msg_entry_t mem [MAX_MSGS];

	// write, and read both ports with write-through
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_data;
		end
		ent_nxt_q <= (wr_en && (wr_slot == rd_addr_nxt)) ? wr_data : mem[rd_addr_nxt];
		ent_cur_q <= (wr_en && (wr_slot == rd_addr_cur)) ? wr_data : mem[rd_addr_cur];
	end

endmodule

>>> src/imss_seq_core.sv
// ----------------------------------------------------------------------------
// imss_seq_core
// Sequencer state and the single-step next-state and result logic. Also
// picks the table addresses to prefetch for the following item.
// ----------------------------------------------------------------------------
module imss_seq_core #(
	parameter int MAX_MSGS = imss_pkg::MAX_MSGS_DEF,
	localparam int IDX_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  imss_pkg::item_t      item,
	input  imss_pkg::msg_entry_t ent_nxt,
	input  imss_pkg::msg_entry_t ent_cur,
	output imss_pkg::result_t    res,
	output logic                 wr_en,
	output logic [IDX_W-1:0]     wr_slot,
	output imss_pkg::msg_entry_t wr_data,
	output logic [IDX_W-1:0]     rd_addr_nxt,
	output logic [IDX_W-1:0]     rd_addr_cur
);
	import imss_pkg::*;

	localparam int CNT_W = $clog2(MAX_MSGS + 1);

	logic [3:0]       phase_q, phase_d;
	logic [CNT_W-1:0] total_q, total_d;
	logic [CNT_W-1:0] cur_q, cur_d;
	logic [15:0]      bytes_left_q, bytes_left_d;
	logic             cur_rd_q, cur_rd_d;
	logic [1:0]       xfer_q, xfer_d;

	logic             next_msg;
	logic [CNT_W-1:0] cur_inc;
	logic [CNT_W-1:0] cur_d_inc;
	logic [CNT_W-1:0] cnt_sat;
	logic [15:0]      bl_dec;
	logic             active;

	assign cur_inc   = cur_q + CNT_W'(1);
	assign cur_d_inc = cur_d + CNT_W'(1);
	assign bl_dec    = bytes_left_q - 16'd1;
	assign active    = (phase_q != PH_IDLE) && (phase_q != PH_ERROR);
	assign cnt_sat   = (32'(item.msg_count) > MAX_MSGS) ? CNT_W'(MAX_MSGS)
	                                                    : CNT_W'(item.msg_count);

	// table write from a load
	assign wr_slot = IDX_W'(item.msg_slot);
	assign wr_data = '{len: item.msg_length, no_start: item.no_start,
	                   rd: item.is_read, addr: item.dev_addr};

	// step logic
	always_comb begin
		phase_d      = phase_q;
		total_d      = total_q;
		cur_d        = cur_q;
		bytes_left_d = bytes_left_q;
		cur_rd_d     = cur_rd_q;
		xfer_d       = xfer_q;
		res          = '0;
		wr_en        = 1'b0;
		next_msg     = 1'b0;
		if (fire) begin
			case (item.req_type)
				REQ_LOAD: begin
					wr_en = (32'(item.msg_slot) < MAX_MSGS);
				end
				REQ_START: begin
					if (!active && (item.msg_count != 4'd0)) begin
						total_d         = cnt_sat;
						cur_d           = '0;
						bytes_left_d    = ent_cur.len;
						cur_rd_d        = ent_cur.rd;
						xfer_d          = ST_OK;
						phase_d         = PH_START;
						res.issue_start = 1'b1;
					end
				end
				REQ_TX_RDY: begin
					if ((phase_q == PH_START) || (phase_q == PH_RESTART)) begin
						res.tx_valid = 1'b1;
						res.tx_data  = {ent_cur.addr, 1'b0} | (ent_cur.rd ? ADDR_RD_BIT : 8'h00);
						phase_d      = cur_rd_q ? PH_ADDR_RD : PH_ADDR_WR;
					end else if ((phase_q == PH_ADDR_WR) || (phase_q == PH_DATA_WR)) begin
						phase_d = PH_DATA_WR;
						if (bytes_left_q != 16'd0) begin
							res.tx_valid   = 1'b1;
							res.tx_data    = item.tx_byte;
							bytes_left_d   = bl_dec;
							res.tx_irq_off = (bl_dec == 16'd0);
						end else begin
							res.tx_irq_off = 1'b1;
						end
					end else if (phase_q == PH_ADDR_RD) begin
						res.enter_receive = 1'b1;
						phase_d           = PH_DATA_RD;
					end
				end
				REQ_RX_RDY: begin
					if ((phase_q == PH_DATA_RD) && (bytes_left_q != 16'd0)) begin
						res.rx_store = 1'b1;
						res.rx_data  = item.rx_byte;
						bytes_left_d = bl_dec;
						res.set_nack = (bl_dec == NACK_AT);
						next_msg     = (bl_dec == 16'd0);
					end
				end
				REQ_TX_END: begin
					if (phase_q == PH_DATA_WR) begin
						next_msg = 1'b1;
					end else if ((phase_q == PH_STOP) && item.stop_seen) begin
						phase_d      = PH_IDLE;
						res.done_res = 1'b1;
						res.status   = xfer_q;
					end
				end
				REQ_ERROR: begin
					if (active) begin
						if (item.err_flags[0]) begin
							xfer_d = ST_NACK;
						end else if (item.err_flags[1]) begin
							xfer_d = ST_ARB;
						end else if (item.err_flags[2]) begin
							xfer_d = ST_TIMEOUT;
						end
						phase_d        = PH_ERROR;
						res.issue_stop = 1'b1;
						res.done_res   = 1'b1;
						res.status     = xfer_d;
					end
				end
				REQ_TIMEOUT: begin
					if (active) begin
						phase_d        = PH_IDLE;
						res.issue_stop = 1'b1;
						res.done_res   = 1'b1;
						res.status     = ST_TIMEOUT;
					end
				end
				default: begin
				end
			endcase
		end
		// advance to the following message or finish with stop
		if (next_msg) begin
			cur_d = cur_inc;
			if (cur_inc >= total_q) begin
				phase_d        = PH_STOP;
				res.issue_stop = 1'b1;
			end else begin
				bytes_left_d = ent_nxt.len;
				cur_rd_d     = ent_nxt.rd;
				if (ent_nxt.no_start) begin
					phase_d = ent_nxt.rd ? PH_DATA_RD : PH_DATA_WR;
				end else begin
					phase_d           = PH_RESTART;
					res.issue_restart = 1'b1;
				end
			end
		end
	end

	// prefetch addresses for the next item: following message, and the
	// current one (entry zero while no transfer runs)
	assign rd_addr_nxt = cur_d_inc[IDX_W-1:0];
	assign rd_addr_cur = ((phase_d == PH_IDLE) || (phase_d == PH_ERROR)) ? '0
	                                                                     : cur_d[IDX_W-1:0];

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			total_q      <= '0;
			cur_q        <= '0;
			bytes_left_q <= '0;
			cur_rd_q     <= 1'b0;
			xfer_q       <= ST_OK;
		end else begin
			phase_q      <= phase_d;
			total_q      <= total_d;
			cur_q        <= cur_d;
			bytes_left_q <= bytes_left_d;
			cur_rd_q     <= cur_rd_d;
			xfer_q       <= xfer_d;
		end
	end

endmodule
